[hw/rtl/decad_pkg.sv]
// decad_pkg: shared types, constants and the frame check function for the
// dual encoder check-bit and angle decoder. No dependencies.
`default_nettype none

package decad_pkg;

  localparam int unsigned FRAME_W = 16;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned ZERO_W  = 15;
  localparam int unsigned ANGLE_W = 16;

  localparam logic [ZERO_W-1:0] FULL_TURN = 15'h4000;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_CAPTURE = 2'd1,
    KIND_LOAD    = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [FRAME_W-1:0]  az_frame;
    logic [FRAME_W-1:0]  alt_frame;
    logic [ZERO_W-1:0]   az_offset_in;
    logic [ZERO_W-1:0]   alt_offset_in;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic                az_bad;
    logic                alt_bad;
    logic [ANGLE_W-1:0]  az_angle;
    logic [ANGLE_W-1:0]  alt_angle;
  } out_item_t;

  // Bit 15 is the inverted parity of odd position bits, bit 14 of even ones.
  function automatic logic frame_good(input logic [FRAME_W-1:0] frame);
    logic odd_chk;
    logic even_chk;
    odd_chk  = ~(frame[13] ^ frame[11] ^ frame[9] ^ frame[7] ^ frame[5] ^ frame[3] ^ frame[1]);
    even_chk = ~(frame[12] ^ frame[10] ^ frame[8] ^ frame[6] ^ frame[4] ^ frame[2] ^ frame[0]);
    return (frame[15] == odd_chk) && (frame[14] == even_chk);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dual_encoder_checkbit_angle_decode.sv]
// Dual encoder check-bit verifier and angle decoder, top level.
// Depends on decad_pkg and decad_calc.
//
// Takes one word per cycle while not stalled by out_tready, holding an azimuth
// and an altitude encoder frame, checks both frames' check bits and returns
// one word with the status flags and the two angles relative to the stored
// zero offsets, in counts of 360/16384 degree. A capture word whose frames
// both pass makes its own readings the new zeros, a load word writes the zeros
// from its offset fields. Throughput is one word per clock without a stall; a
// word passes the input register, then the result register fed by the
// single-pass decode logic. The zero registers update as a word moves on to
// the result register, so the next word always sees them. Backpressure on out_tready propagates to in_tready.
`default_nettype none

module dual_encoder_checkbit_angle_decode (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [15:0] az_frame, [31:16] alt_frame, [46:32] az_offset_in,
  // [61:47] alt_offset_in, [63:62] zero
  input  wire  [63:0] in_tdata,
  // [1:0] kind
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [15:0] az_angle, [31:16] alt_angle
  output logic [31:0] out_tdata,
  // [0] ok, [1] az_bad, [2] alt_bad
  output logic [2:0]  out_tuser
);

  logic                           s1_v_r;
  decad_pkg::in_item_t            s1_r;
  logic                           out_v_r;
  decad_pkg::out_item_t           out_r;
  logic [decad_pkg::ZERO_W-1:0]   az_zero_r;
  logic [decad_pkg::ZERO_W-1:0]   alt_zero_r;

  decad_pkg::in_item_t            in_item;
  decad_pkg::out_item_t           res;
  logic [decad_pkg::ZERO_W-1:0]   az_zero_nxt;
  logic [decad_pkg::ZERO_W-1:0]   alt_zero_nxt;
  logic                           out_free;
  logic                           s1_adv;
  logic                           in_acc;

  assign in_item.kind          = decad_pkg::kind_t'(in_tuser);
  assign in_item.az_frame      = in_tdata[15:0];
  assign in_item.alt_frame     = in_tdata[31:16];
  assign in_item.az_offset_in  = in_tdata[46:32];
  assign in_item.alt_offset_in = in_tdata[61:47];

  assign out_free  = ~out_v_r | out_tready;
  assign s1_adv    = s1_v_r & out_free;
  assign in_tready = ~s1_v_r | out_free;
  assign in_acc    = in_tvalid & in_tready;

  decad_calc u_calc (
    .item         (s1_r),
    .az_zero      (az_zero_r),
    .alt_zero     (alt_zero_r),
    .res          (res),
    .az_zero_nxt  (az_zero_nxt),
    .alt_zero_nxt (alt_zero_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      az_zero_r  <= '0;
      alt_zero_r <= '0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
      // advance zeros only when the word leaves the input register
      if (s1_adv) begin
        az_zero_r  <= az_zero_nxt;
        alt_zero_r <= alt_zero_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_item;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.alt_angle, out_r.az_angle};
  assign out_tuser  = {out_r.alt_bad, out_r.az_bad, out_r.ok};

endmodule

`default_nettype wire

[hw/rtl/decad_calc.sv]
// decad_calc: combinational check-bit test, offset update and angle math for
// one item. Depends on decad_pkg.
`default_nettype none

module decad_calc (
  input  var decad_pkg::in_item_t          item,
  input  wire [decad_pkg::ZERO_W-1:0]      az_zero,
  input  wire [decad_pkg::ZERO_W-1:0]      alt_zero,
  output decad_pkg::out_item_t             res,
  output logic [decad_pkg::ZERO_W-1:0]     az_zero_nxt,
  output logic [decad_pkg::ZERO_W-1:0]     alt_zero_nxt
);

  logic                            az_ok;
  logic                            alt_ok;
  logic [decad_pkg::POS_W-1:0]     az_raw;
  logic [decad_pkg::POS_W-1:0]     alt_raw;
  logic [decad_pkg::ZERO_W-1:0]    az_zero_use;
  logic [decad_pkg::ZERO_W-1:0]    alt_zero_use;

  assign az_ok   = decad_pkg::frame_good(item.az_frame);
  assign alt_ok  = decad_pkg::frame_good(item.alt_frame);
  assign az_raw  = item.az_frame[decad_pkg::POS_W-1:0];
  assign alt_raw = item.alt_frame[decad_pkg::POS_W-1:0];

  always_comb begin
    az_zero_use  = az_zero;
    alt_zero_use = alt_zero;
    res.ok       = 1'b0;
    res.az_bad   = ~az_ok;
    res.alt_bad  = ~alt_ok;
    res.az_angle = '0;
    res.alt_angle = '0;
    az_zero_nxt  = az_zero;
    alt_zero_nxt = alt_zero;

    case (item.kind)
      decad_pkg::KIND_LOAD: begin
        az_zero_nxt  = item.az_offset_in;
        alt_zero_nxt = item.alt_offset_in;
        res.ok       = 1'b1;
        res.az_bad   = 1'b0;
        res.alt_bad  = 1'b0;
      end
      default: begin
        if (az_ok && alt_ok) begin
          if (item.kind == decad_pkg::KIND_CAPTURE) begin
            az_zero_use  = {1'b0, az_raw};
            alt_zero_use = decad_pkg::FULL_TURN - {1'b0, alt_raw};
          end
          az_zero_nxt   = az_zero_use;
          alt_zero_nxt  = alt_zero_use;
          res.ok        = 1'b1;
          res.az_angle  = {2'b00, az_raw} - {1'b0, az_zero_use};
          res.alt_angle = {1'b0, decad_pkg::FULL_TURN} - {2'b00, alt_raw}
                          - {1'b0, alt_zero_use};
        end
      end
    endcase
  end

endmodule

`default_nettype wire
